### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### rtl/fcull_pkg.sv
`timescale 1ns / 1ps

package fcull_pkg;

   // Plane registers and lanes
   localparam int NUM_PLANES_DEF = 6;
   localparam int PLANE_REGS     = 6;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;

   // Field widths
   localparam int COORD_W = 24;   // signed Q16.8
   localparam int EXT_W   = 23;   // unsigned Q15.8
   localparam int COEF_W  = 14;   // signed Q1.13
   localparam int OFFS_W  = 22;   // signed Q14.8 plane offset
   localparam int FRAC_SHIFT = 13;

   // Datapath widths (21 fraction bits)
   localparam int PROD_W = COEF_W + COORD_W;   // a*x
   localparam int QPROD_W = COEF_W + EXT_W;    // |a|*ex
   localparam int DC_W   = PROD_W + 3;         // centre distance
   localparam int MG_W   = QPROD_W + 2;        // margin, unsigned
   localparam int SUM_W  = DC_W + 1;           // centre distance plus margin

   // Coefficient positions within a plane register
   localparam int A_LSB = 50;
   localparam int B_LSB = 36;
   localparam int C_LSB = 22;

   typedef enum logic [1:0] {
      FUNC_POINT  = 2'd0,
      FUNC_CUBE   = 2'd1,
      FUNC_SPHERE = 2'd2,
      FUNC_BOX    = 2'd3
   } func_type;

   // Load enables for the lane pipeline registers
   typedef struct packed {
      logic load1;
      logic load2;
   } pipe_en_type;

endpackage

### rtl/fcull_if.sv
`timescale 1ns / 1ps

// Primitive word channel
interface fcull_req_if
   import fcull_pkg::*;
();
   logic                      valid;
   logic                      ready;
   func_type                  func;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] center_z;
   logic [EXT_W-1:0]          extent_x;
   logic [EXT_W-1:0]          extent_y;
   logic [EXT_W-1:0]          extent_z;

   modport source (output valid, func, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, input ready);
   modport sink   (input valid, func, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, output ready);
endinterface

// Result word channel
interface fcull_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

### rtl/fcull_lane.sv
`timescale 1ns / 1ps

// One plane: products, then distance and margin, then the reject decision.
module fcull_lane
   import fcull_pkg::*;
(
   input  logic                      clock,
   input  logic [CSR_DATA_W-1:0]     plane,
   input  pipe_en_type               pipe_en,
   input  func_type                  func,
   input  logic signed [COORD_W-1:0] cx,
   input  logic signed [COORD_W-1:0] cy,
   input  logic signed [COORD_W-1:0] cz,
   input  logic [EXT_W-1:0]          ex,
   input  logic [EXT_W-1:0]          ey,
   input  logic [EXT_W-1:0]          ez,
   output logic                      reject
);

   logic signed [COEF_W-1:0] a, b, c;
   logic signed [OFFS_W-1:0] d;
   logic [COEF_W-1:0]        abs_a, abs_b, abs_c;
   logic [EXT_W-1:0]         ey_sel, ez_sel;

   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff;
   logic [QPROD_W-1:0]       qa_ff, qb_ff, qc_ff;
   logic signed [OFFS_W-1:0] d_ff;
   logic [EXT_W-1:0]         rad_ff;
   func_type                 func_ff;

   logic signed [DC_W-1:0]   dc_in, dc_ff;
   logic [MG_W-1:0]          mg_in, mg_ff;
   logic signed [SUM_W-1:0]  dmax;

   // Unpack coefficients; |a| of -1.0 needs the full 14 bits unsigned
   assign a = plane[A_LSB +: COEF_W];
   assign b = plane[B_LSB +: COEF_W];
   assign c = plane[C_LSB +: COEF_W];
   assign d = plane[OFFS_W-1:0];
   assign abs_a = a[COEF_W-1] ? COEF_W'(-a) : COEF_W'(a);
   assign abs_b = b[COEF_W-1] ? COEF_W'(-b) : COEF_W'(b);
   assign abs_c = c[COEF_W-1] ? COEF_W'(-c) : COEF_W'(c);

   // Cube uses its single half size on all axes
   assign ey_sel = (func == FUNC_CUBE) ? ex : ey;
   assign ez_sel = (func == FUNC_CUBE) ? ex : ez;

   // Stage 1: multipliers
   always_ff @(posedge clock) begin
      if (pipe_en.load1) begin
         pa_ff   <= a * cx;
         pb_ff   <= b * cy;
         pc_ff   <= c * cz;
         qa_ff   <= abs_a * ex;
         qb_ff   <= abs_b * ey_sel;
         qc_ff   <= abs_c * ez_sel;
         d_ff    <= d;
         rad_ff  <= ex;
         func_ff <= func;
      end
   end

   // Stage 2: centre distance and per-kind margin
   assign dc_in = DC_W'(pa_ff) + DC_W'(pb_ff) + DC_W'(pc_ff)
                + (DC_W'(d_ff) <<< FRAC_SHIFT);

   always_comb begin
      unique case (func_ff)
         FUNC_POINT:  mg_in = '0;
         FUNC_SPHERE: mg_in = MG_W'(rad_ff) << FRAC_SHIFT;
         FUNC_CUBE,
         FUNC_BOX:    mg_in = MG_W'(qa_ff) + MG_W'(qb_ff) + MG_W'(qc_ff);
         default:     mg_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en.load2) begin
         dc_ff <= dc_in;
         mg_ff <= mg_in;
      end
   end

   // Rejected when even the farthest extent stays behind the plane
   assign dmax   = SUM_W'(dc_ff) + $signed(SUM_W'(mg_ff));
   assign reject = dmax[SUM_W-1];

endmodule

### rtl/frustum_cull_test.sv
`timescale 1ns / 1ps

// Six-plane frustum test for points, cubes, spheres and axis-aligned boxes.
// req_ch carries one primitive per word: kind, centre (Q16.8) and extents.
// rsp_ch returns one word per primitive: visible = 1 unless some plane
// rejects it. Words come out in the order they went in.
// Planes are loaded through csr_we/csr_index/csr_wdata, index 0..5 for
// near, far, left, right, top, bottom; other indexes are dropped. Load
// planes only while no primitive is in flight.
// From acceptance the input register takes the word, then it passes the
// multiplier stage and the distance stage to the result register, which
// drives rsp_ch.valid.
// Throughput: one primitive per cycle unless rsp_ch stalls; every plane
// has its own lane of multipliers, so all planes are tested in parallel.
// Stall: each stage holds while the one after it is full and stalled, so
// up to four words are buffered before req_ch.ready drops.
// Reset clears the pipeline and all planes; cleared planes never reject.
module frustum_cull_test
   import fcull_pkg::*;
#(
   parameter int NUM_PLANES = NUM_PLANES_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   fcull_req_if.sink             req_ch,
   fcull_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CSR_DATA_W-1:0] plane_ff [PLANE_REGS];

   logic                      v0_ff, v1_ff, v2_ff, rsp_valid_ff, visible_ff;
   logic                      free0, free1, free2, free3;
   func_type                  func_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [EXT_W-1:0]          ex_ff, ey_ff, ez_ff;
   pipe_en_type               pipe_en;
   logic [NUM_PLANES-1:0]     reject;

   // Plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < CSR_IDX_W'(PLANE_REGS))) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   // Stage advance: a stage loads when it is empty or its word moves on
   assign free3 = !rsp_valid_ff || rsp_ch.ready;
   assign free2 = !v2_ff || free3;
   assign free1 = !v1_ff || free2;
   assign free0 = !v0_ff || free1;

   assign req_ch.ready  = free0;
   assign pipe_en.load1 = free1;
   assign pipe_en.load2 = free2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (free0) v0_ff <= req_ch.valid;
         if (free1) v1_ff <= v0_ff;
         if (free2) v2_ff <= v1_ff;
         if (free3) rsp_valid_ff <= v2_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (free0) begin
         func_ff <= req_ch.func;
         cx_ff   <= req_ch.center_x;
         cy_ff   <= req_ch.center_y;
         cz_ff   <= req_ch.center_z;
         ex_ff   <= req_ch.extent_x;
         ey_ff   <= req_ch.extent_y;
         ez_ff   <= req_ch.extent_z;
      end
   end

   // One lane per plane; planes without a register read as zero
   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
      logic [CSR_DATA_W-1:0] plane_sel;

      if (g < PLANE_REGS) begin : g_reg
         assign plane_sel = plane_ff[g];
      end else begin : g_zero
         assign plane_sel = '0;
      end

      fcull_lane u_lane (
         .clock   (clock),
         .plane   (plane_sel),
         .pipe_en (pipe_en),
         .func    (func_ff),
         .cx      (cx_ff),
         .cy      (cy_ff),
         .cz      (cz_ff),
         .ex      (ex_ff),
         .ey      (ey_ff),
         .ez      (ez_ff),
         .reject  (reject[g])
      );
   end

   // Result register
   always_ff @(posedge clock) begin
      if (free3) visible_ff <= ~|reject;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.visible = visible_ff;

endmodule

### rtl/fcull_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the frustum test block.
module fcull_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // A stalled result word stays and keeps its value
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_visible))

   // Reset empties the pipeline
   `ASSERT_CLK_NR(a_reset_empty, clock, reset |=> !rsp_valid)

   // With the receiver taking words, an accepted primitive passes the
   // multiplier and distance stages into the result register
   `ASSERT_CLK(a_latency, clock, reset, req_acc ##1 rsp_ready[*3] |=> rsp_valid)

endmodule

bind frustum_cull_test fcull_chk u_fcull_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_visible (rsp_ch.visible)
);
